### hdl/dhoat_pkg.sv
// ----------------------------------------------------------------------------
// dhoat_pkg
// Shared types and constants for the double hashing open address table.
// ----------------------------------------------------------------------------
package dhoat_pkg;

  localparam int SLOT_DEPTH = 1024;
  localparam int SLOT_W     = $clog2(SLOT_DEPTH);
  localparam int SIZE_W     = 11;
  localparam int KEY_W      = 31;
  localparam int PAY_W      = 32;
  localparam int FOLD_SHIFT = 10;
  localparam int SIZE_RESET = 1021;
  localparam int DIV_STEPS  = KEY_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int SLOT_BITS  = 1 + KEY_W + PAY_W;

  typedef enum logic [1:0] {
    KIND_OPEN_INS   = 2'd0,
    KIND_OPEN_LOOK  = 2'd1,
    KIND_DIRECT_INS = 2'd2,
    KIND_DIRECT_LOOK = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RES_FAIL = 2'd0,
    RES_INS  = 2'd1,
    RES_HIT  = 2'd2
  } outcome_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SEED,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] record_payload;
  } item_t;

  typedef struct packed {
    logic              success;
    logic [KEY_W-1:0]  found_key;
    logic [PAY_W-1:0]  found_payload;
    logic [SLOT_W-1:0] slot_index;
  } result_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } slot_t;

  typedef struct packed {
    logic     clr;
    logic     load;
    logic     div_step;
    logic     seed;
    logic     adv;
    logic     wr;
    logic     inc;
    logic     pend;
    outcome_t res;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic  clr_last;
    logic  div_done;
    logic  full;
    logic  slot_valid;
    logic  key_match;
    logic  probe_last;
    kind_t kind;
    logic  out_free;
  } status_t;

endpackage

### hdl/double_hash_open_address_table.sv
// ----------------------------------------------------------------------------
// double_hash_open_address_table
// Keyed record table with open (double hashing) and direct addressing.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the 1024-slot store and
// accepts no item until it ends. Each item then passes through an accept
// state, a bit-serial run over the key bits for the remainders (home mod size,
// key mod size-1), a seed state, a read and a check state per probe (slot
// read is registered) and a handoff state, which waits while the previous
// result still waits on the output. An open search reads at most size slots.
// One item is in flight at a time; a finished result may wait on the output
// while the next item is taken.
module double_hash_open_address_table import dhoat_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_data,
  input  logic              item_valid,
  output logic              item_stall,
  input  item_t             item,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result
);

  cmd_t    cmd;
  status_t st;

  dhoat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .st        (st),
    .cmd       (cmd)
  );

  dhoat_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cmd         (cmd),
    .st          (st)
  );

endmodule

### hdl/dhoat_ram.sv
// ----------------------------------------------------------------------------
// dhoat_ram
// Generic simple dual port RAM with registered read.
// ----------------------------------------------------------------------------
module dhoat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/dhoat_ctrl.sv
// ----------------------------------------------------------------------------
// dhoat_ctrl
// Sequencer: clearing pass, remainder run, probe loop, result handoff.
// ----------------------------------------------------------------------------
module dhoat_ctrl import dhoat_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res    = RES_FAIL;
    item_stall = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) begin
          state_next = ST_SEED;
        end
      end
      ST_SEED: begin
        cmd.seed   = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = ST_FINISH;
        cmd.pend   = 1'b1;
        unique case (st.kind)
          KIND_OPEN_INS: begin
            if (st.full) begin
              cmd.res = RES_FAIL;
            end else if (!st.slot_valid) begin
              cmd.res = RES_INS;
              cmd.wr  = 1'b1;
              cmd.inc = 1'b1;
            end else if (!st.probe_last) begin
              cmd.pend   = 1'b0;
              cmd.adv    = 1'b1;
              state_next = ST_READ;
            end
          end
          KIND_OPEN_LOOK: begin
            if (!st.slot_valid) begin
              cmd.res = RES_FAIL;
            end else if (st.key_match) begin
              cmd.res = RES_HIT;
            end else if (!st.probe_last) begin
              cmd.pend   = 1'b0;
              cmd.adv    = 1'b1;
              state_next = ST_READ;
            end
          end
          KIND_DIRECT_INS: begin
            if (!st.full) begin
              cmd.res = RES_INS;
              cmd.wr  = 1'b1;
              cmd.inc = !st.slot_valid;
            end
          end
          KIND_DIRECT_LOOK: begin
            if (st.slot_valid) begin
              cmd.res = RES_HIT;
            end
          end
          default: begin
            cmd.res = RES_FAIL;
          end
        endcase
      end
      ST_FINISH: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/dhoat_dp.sv
// ----------------------------------------------------------------------------
// dhoat_dp
// Datapath: size register, bit-serial remainders, probe pointer, slot store,
// entry count and result register.
// ----------------------------------------------------------------------------
module dhoat_dp import dhoat_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_data,
  input  item_t             item,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result,
  input  cmd_t              cmd,
  output status_t           st
);

  logic [SIZE_W-1:0]    active_size;
  logic [SIZE_W-1:0]    size_m1;
  logic [1:0]           kind;
  logic [KEY_W-1:0]     key;
  logic [PAY_W-1:0]     payload;
  logic [KEY_W-1:0]     sh_home;
  logic [KEY_W-1:0]     sh_key;
  logic [SIZE_W-1:0]    rem_home;
  logic [SIZE_W-1:0]    rem_key;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [SLOT_W-1:0]    probe;
  logic [SLOT_W-1:0]    probe_cnt;
  logic [SLOT_W-1:0]    clr_idx;
  logic [SIZE_W-1:0]    entry_count;
  logic [KEY_W-1:0]     home;
  logic [SIZE_W-1:0]    step;
  logic [SIZE_W:0]      adv_sum;
  logic [SLOT_W-1:0]    probe_adv;
  slot_t                rd_slot;
  slot_t                wr_slot;
  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_waddr;
  result_t              pend;

  function automatic logic [SIZE_W-1:0] rem_bit(input logic [SIZE_W-1:0] r,
                                                input logic              b,
                                                input logic [SIZE_W-1:0] d);
    logic [SIZE_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[SIZE_W-1:0];
  endfunction

  // table size with saturation on write
  always_ff @(posedge clk) begin
    if (rst) begin
      active_size <= SIZE_W'(SIZE_RESET);
    end else if (cfg_we) begin
      if (cfg_data < SIZE_W'(2)) begin
        active_size <= SIZE_W'(2);
      end else if (cfg_data > SIZE_W'(SLOT_DEPTH)) begin
        active_size <= SIZE_W'(SLOT_DEPTH);
      end else begin
        active_size <= cfg_data;
      end
    end
  end

  assign size_m1 = active_size - SIZE_W'(1);
  assign home    = (item.key >> FOLD_SHIFT) ^ (item.key & KEY_W'(size_m1));
  assign step    = rem_key + SIZE_W'(1);
  assign adv_sum = {2'b00, probe} + {1'b0, step};
  assign probe_adv = (adv_sum >= {1'b0, active_size}) ?
                     SLOT_W'(adv_sum - {1'b0, active_size}) : SLOT_W'(adv_sum);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind     <= item.kind;
      key      <= item.key;
      payload  <= item.record_payload;
      sh_home  <= home;
      sh_key   <= item.key;
      rem_home <= '0;
      rem_key  <= '0;
      div_cnt  <= '0;
    end else if (cmd.div_step) begin
      rem_home <= rem_bit(rem_home, sh_home[KEY_W-1], active_size);
      rem_key  <= rem_bit(rem_key, sh_key[KEY_W-1], size_m1);
      sh_home  <= sh_home << 1;
      sh_key   <= sh_key << 1;
      div_cnt  <= div_cnt + DIV_CNT_W'(1);
    end
    if (cmd.seed) begin
      probe     <= SLOT_W'(rem_home);
      probe_cnt <= '0;
    end else if (cmd.adv) begin
      probe     <= probe_adv;
      probe_cnt <= probe_cnt + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx     <= '0;
      entry_count <= '0;
    end else begin
      if (cmd.clr) begin
        clr_idx <= clr_idx + SLOT_W'(1);
      end
      if (cmd.inc) begin
        entry_count <= entry_count + SIZE_W'(1);
      end
    end
  end

  assign ram_we    = cmd.clr | cmd.wr;
  assign ram_waddr = cmd.clr ? clr_idx : probe;
  assign wr_slot   = cmd.clr ? slot_t'('0) : slot_t'({1'b1, key, payload});

  dhoat_ram #(
    .WIDTH(SLOT_BITS),
    .DEPTH(SLOT_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_slot),
    .raddr(probe),
    .rdata(rd_slot)
  );

  always_ff @(posedge clk) begin
    if (cmd.pend) begin
      case (cmd.res)
        RES_INS: begin
          pend <= '{success: 1'b1, found_key: '0, found_payload: '0,
                    slot_index: probe};
        end
        RES_HIT: begin
          pend <= '{success: 1'b1, found_key: rd_slot.key,
                    found_payload: rd_slot.payload, slot_index: probe};
        end
        default: begin
          pend <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result <= pend;
    end
  end

  assign st.clr_last   = (clr_idx == {SLOT_W{1'b1}});
  assign st.div_done   = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign st.full       = (entry_count >= active_size);
  assign st.slot_valid = rd_slot.valid;
  assign st.key_match  = (rd_slot.key == key);
  assign st.probe_last = ({1'b0, probe_cnt} == size_m1);
  assign st.kind       = kind_t'(kind);
  assign st.out_free   = !result_valid || !result_stall;

endmodule
